/* hw/rtl/wsq_pkg.sv */
// Package for the work-stealing task queues: operation and status codes,
// request/response payload structs and the command metadata passed front to back.
// No dependencies.
package wsq_pkg;

	// Operation codes of a request.
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;

	// Status codes of a response.
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_NONE = 2'd1;
	localparam logic [1:0] STATUS_DROP = 2'd2;

	// Request payload.
	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  queue_index;
		logic [15:0] task_id;
	} wsq_req_t;

	// Response payload.
	typedef struct packed {
		logic [1:0]  status;
		logic        task_valid;
		logic [15:0] task_out;
		logic [1:0]  source_queue;
		logic        stolen;
	} wsq_rsp_t;

	// Control part of one command that the front hands to the back.
	typedef struct packed {
		logic       wr;
		logic       rd;
		logic [1:0] status;
		logic [1:0] source;
		logic       stolen;
	} wsq_meta_t;

	localparam int unsigned META_BITS = $bits(wsq_meta_t);

endpackage

/* hw/rtl/wsq_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module wsq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read at the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/wsq_fifo.sv */
// Short command queue that decouples the front classifier from the back executor.
// No dependencies.
module wsq_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty,
	output logic             full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Storage slots need no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/wsq_front.sv */
// Front end: accepts requests, keeps head/tail pointers and occupancy per queue,
// picks the queue to serve and issues one memory command. Depends on wsq_pkg.
module wsq_front import wsq_pkg::*; #(
	parameter int unsigned NUM_QUEUE    = 4,
	parameter int unsigned QUEUE_DEPTH  = 16,
	parameter int unsigned TASK_ID_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  wsq_req_t                              req,
	output logic                                  cmd_valid,
	output logic [META_BITS+$clog2(NUM_QUEUE*QUEUE_DEPTH)+TASK_ID_BITS-1:0] cmd
);

	localparam int unsigned QW = $clog2(NUM_QUEUE);
	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned AW = $clog2(NUM_QUEUE * QUEUE_DEPTH);

	logic [PW-1:0] head_q [NUM_QUEUE];
	logic [PW-1:0] tail_q [NUM_QUEUE];
	logic [OW-1:0] occ_q  [NUM_QUEUE];

	logic [31:0]       q_ext;
	logic [31:0]       task_ext;
	logic              own_ok;
	logic [QW-1:0]     q_idx;
	logic [OW-1:0]     own_occ;
	logic              steal_found;
	logic [QW-1:0]     steal_idx;
	logic [31:0]       steal_ext;
	logic              do_push;
	logic              do_take;
	logic [QW-1:0]     sel_q;
	logic [PW-1:0]     sel_ptr;
	logic [AW-1:0]     addr;
	wsq_meta_t         meta;

	assign q_ext    = 32'(req.queue_index);
	assign task_ext = 32'(req.task_id);
	assign own_ok   = (q_ext < NUM_QUEUE);
	assign q_idx    = q_ext[QW-1:0];
	assign own_occ  = own_ok ? occ_q[q_idx] : '0;

	// Lowest-numbered non-empty queue; the own queue is only chosen here when
	// it is empty, so it never wins.
	always_comb begin
		steal_found = 1'b0;
		steal_idx   = '0;
		for (int i = NUM_QUEUE - 1; i >= 0; i--) begin
			if (occ_q[i] != '0) begin
				steal_found = 1'b1;
				steal_idx   = QW'(i);
			end
		end
	end

	assign steal_ext = 32'(steal_idx);

	// Classify the request and build its memory command.
	always_comb begin
		meta        = '0;
		meta.status = STATUS_NONE;
		do_push     = 1'b0;
		do_take     = 1'b0;
		sel_q       = q_idx;
		case (req.operation)
			OP_PUSH: begin
				if (own_ok && own_occ != OW'(QUEUE_DEPTH)) begin
					do_push     = 1'b1;
					meta.wr     = 1'b1;
					meta.status = STATUS_OK;
				end else begin
					meta.status = STATUS_DROP;
				end
			end
			OP_POP, OP_DRAIN: begin
				if (own_ok && own_occ != '0) begin
					do_take     = 1'b1;
					meta.rd     = 1'b1;
					meta.status = STATUS_OK;
					meta.source = req.queue_index;
				end else if (req.operation == OP_POP && steal_found) begin
					do_take     = 1'b1;
					sel_q       = steal_idx;
					meta.rd     = 1'b1;
					meta.stolen = 1'b1;
					meta.status = STATUS_OK;
					meta.source = steal_ext[1:0];
				end
			end
			default: begin
				meta.status = STATUS_NONE;
			end
		endcase
		sel_ptr = do_push ? tail_q[sel_q] : head_q[sel_q];
		addr    = AW'(sel_q) * AW'(QUEUE_DEPTH) + AW'(sel_ptr);
	end

	assign cmd_valid = accept;
	assign cmd       = {meta, addr, task_ext[TASK_ID_BITS-1:0]};

	// Pointer and occupancy update for the served queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUE; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < NUM_QUEUE; i++) begin
				if (sel_q == QW'(i)) begin
					if (do_push) begin
						tail_q[i] <= (tail_q[i] == PW'(QUEUE_DEPTH - 1)) ?
							'0 : tail_q[i] + 1'b1;
						occ_q[i]  <= occ_q[i] + 1'b1;
					end
					if (do_take) begin
						head_q[i] <= (head_q[i] == PW'(QUEUE_DEPTH - 1)) ?
							'0 : head_q[i] + 1'b1;
						occ_q[i]  <= occ_q[i] - 1'b1;
					end
				end
			end
		end
	end

endmodule

/* hw/rtl/wsq_back.sv */
// Back end: executes queued memory commands on the task store and forms responses.
// Depends on wsq_pkg and wsq_ram.
module wsq_back import wsq_pkg::*; #(
	parameter int unsigned NUM_QUEUE    = 4,
	parameter int unsigned QUEUE_DEPTH  = 16,
	parameter int unsigned TASK_ID_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	input  logic [META_BITS+$clog2(NUM_QUEUE*QUEUE_DEPTH)+TASK_ID_BITS-1:0] cmd,
	output logic                                  cmd_pop,
	output logic                                  done,
	output wsq_rsp_t                              rsp
);

	localparam int unsigned AW = $clog2(NUM_QUEUE * QUEUE_DEPTH);

	wsq_meta_t               meta;
	logic [AW-1:0]           addr;
	logic [TASK_ID_BITS-1:0] wdata;
	logic [TASK_ID_BITS-1:0] rdata;
	logic [31:0]             rdata_ext;
	logic                    valid_s1;
	wsq_meta_t               meta_s1;
	logic                    done_q;
	wsq_rsp_t                rsp_q;

	assign {meta, addr, wdata} = cmd;

	// The back never stalls: a waiting command is taken every cycle.
	assign cmd_pop = cmd_valid;

	wsq_ram #(
		.WIDTH(TASK_ID_BITS),
		.DEPTH(NUM_QUEUE * QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd_valid && meta.wr),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign rdata_ext = 32'(rdata);

	// Stage 1 tracks the command while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= meta;
	end

	// Response register: strobe for one cycle per command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.status       <= meta_s1.status;
		rsp_q.task_valid   <= meta_s1.rd;
		rsp_q.task_out     <= meta_s1.rd ? rdata_ext[15:0] : '0;
		rsp_q.source_queue <= meta_s1.source;
		rsp_q.stolen       <= meta_s1.stolen;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* hw/rtl/work_stealing_task_queues.sv */
// Work-stealing task queues: NUM_QUEUE FIFO queues of task identifiers.
// Top level; depends on wsq_pkg, wsq_front, wsq_fifo, wsq_back and wsq_ram.
//
// Usage:
//   Request channel: drive req and raise start; the transfer happens at a rising
//   edge with start high and busy low. operation selects push, pop with stealing
//   or drain pop; queue_index names the queue.
//   Response channel: every request gives one response on rsp, marked by done
//   for exactly one cycle. The receiver cannot stall, so it must take it then.
//   A command passes the command queue, stage 1 (the store read) and the response
//   register before done rises. Throughput: one request per cycle; the front
//   updates pointers and occupancy in the accepting cycle, and the task store
//   port in the back does one read or write per cycle, so busy stays low.
//   A pop with an empty own queue steals the head of the lowest-numbered
//   non-empty queue and sets stolen.
//   Reset empties all queues at once (pointers and counts cleared); the task
//   store itself is not cleared, no unwritten entry is ever read.
module work_stealing_task_queues import wsq_pkg::*; #(
	parameter int unsigned NUM_QUEUE    = 4,
	parameter int unsigned QUEUE_DEPTH  = 16,
	parameter int unsigned TASK_ID_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  wsq_req_t req,
	output logic     done,
	output wsq_rsp_t rsp
);

	localparam int unsigned CMD_BITS = META_BITS + $clog2(NUM_QUEUE * QUEUE_DEPTH)
		+ TASK_ID_BITS;
	localparam int unsigned CMD_DEPTH = 4;

	logic                accept;
	logic                push_valid;
	logic [CMD_BITS-1:0] push_cmd;
	logic [CMD_BITS-1:0] head_cmd;
	logic                fifo_empty;
	logic                fifo_full;
	logic                cmd_pop;

	assign busy   = fifo_full;
	assign accept = start && !fifo_full;

	wsq_front #(
		.NUM_QUEUE   (NUM_QUEUE),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_ID_BITS(TASK_ID_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.cmd_valid(push_valid),
		.cmd      (push_cmd)
	);

	wsq_fifo #(
		.WIDTH(CMD_BITS),
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_data(push_cmd),
		.pop      (cmd_pop),
		.pop_data (head_cmd),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	wsq_back #(
		.NUM_QUEUE   (NUM_QUEUE),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_ID_BITS(TASK_ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!fifo_empty),
		.cmd      (head_cmd),
		.cmd_pop  (cmd_pop),
		.done     (done),
		.rsp      (rsp)
	);

endmodule
